// ===== hw/rtl/mexp_pkg.sv =====
// Shared types, constants and the microprogram of the modular exponentiation unit.
// Depends on nothing; imported by mexp_mulmod and modular_exponentiation_unit.
`default_nettype none

package mexp_pkg;

    localparam int MOD_W  = 31;
    localparam int OPD_W  = 32;
    localparam int STEP_W = 4;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    // Step addresses of the microprogram.
    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_REDUCE = 4'd1;
    localparam logic [STEP_W-1:0] STEP_WAIT_R = 4'd2;
    localparam logic [STEP_W-1:0] STEP_TEST   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_BIT    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_MULT   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_WAIT_M = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SQR    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_WAIT_S = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LOOP   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_DONE   = 4'd11;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_ACCEPT = 2'd1,
        ACT_MUL    = 2'd2,
        ACT_EMIT   = 2'd3
    } t_act;

    typedef enum logic [0:0] {
        OPA_ONE = 1'b0,
        OPA_PW  = 1'b1
    } t_opa;

    typedef enum logic [1:0] {
        OPB_BASE = 2'd0,
        OPB_ACC  = 2'd1,
        OPB_PW   = 2'd2
    } t_opb;

    typedef enum logic [0:0] {
        DEST_PW  = 1'b0,
        DEST_ACC = 1'b1
    } t_dest;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_NO_INPUT = 3'd2,
        COND_MUL_BUSY = 3'd3,
        COND_EXP_ZERO = 3'd4,
        COND_EXP_EVEN = 3'd5,
        COND_OUT_FULL = 3'd6
    } t_cond;

    // One control word: what to do in this step and where to go next.
    typedef struct packed {
        t_act              act;
        t_opa              opa;
        t_opb              opb;
        t_dest             dest;
        logic              shift;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic             start;
        logic [MOD_W-1:0] a;
        logic [OPD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MOD_W-1:0] result;
    } t_mul_rsp;

    function automatic t_uword uw(input t_act act, input t_opa opa, input t_opb opb,
                                  input t_dest dest, input logic shift, input t_cond cond,
                                  input logic [STEP_W-1:0] target);
        t_uword w;
        w.act    = act;
        w.opa    = opa;
        w.opb    = opb;
        w.dest   = dest;
        w.shift  = shift;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Microprogram ROM. A true condition jumps to the target, otherwise the
    // step counter advances by one.
    function automatic t_uword uprog(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            STEP_IDLE:   w = uw(ACT_ACCEPT, OPA_ONE, OPB_BASE, DEST_PW, 1'b0,
                                COND_NO_INPUT, STEP_IDLE);
            STEP_REDUCE: w = uw(ACT_MUL, OPA_ONE, OPB_BASE, DEST_PW, 1'b0,
                                COND_NEVER, STEP_IDLE);
            STEP_WAIT_R: w = uw(ACT_NONE, OPA_ONE, OPB_BASE, DEST_PW, 1'b0,
                                COND_MUL_BUSY, STEP_WAIT_R);
            STEP_TEST:   w = uw(ACT_NONE, OPA_ONE, OPB_BASE, DEST_PW, 1'b0,
                                COND_EXP_ZERO, STEP_EMIT);
            STEP_BIT:    w = uw(ACT_NONE, OPA_ONE, OPB_BASE, DEST_PW, 1'b0,
                                COND_EXP_EVEN, STEP_SQR);
            STEP_MULT:   w = uw(ACT_MUL, OPA_PW, OPB_ACC, DEST_ACC, 1'b0,
                                COND_NEVER, STEP_IDLE);
            STEP_WAIT_M: w = uw(ACT_NONE, OPA_ONE, OPB_BASE, DEST_PW, 1'b0,
                                COND_MUL_BUSY, STEP_WAIT_M);
            STEP_SQR:    w = uw(ACT_MUL, OPA_PW, OPB_PW, DEST_PW, 1'b1,
                                COND_NEVER, STEP_IDLE);
            STEP_WAIT_S: w = uw(ACT_NONE, OPA_ONE, OPB_BASE, DEST_PW, 1'b0,
                                COND_MUL_BUSY, STEP_WAIT_S);
            STEP_LOOP:   w = uw(ACT_NONE, OPA_ONE, OPB_BASE, DEST_PW, 1'b0,
                                COND_ALWAYS, STEP_TEST);
            STEP_EMIT:   w = uw(ACT_EMIT, OPA_ONE, OPB_BASE, DEST_PW, 1'b0,
                                COND_OUT_FULL, STEP_EMIT);
            STEP_DONE:   w = uw(ACT_NONE, OPA_ONE, OPB_BASE, DEST_PW, 1'b0,
                                COND_ALWAYS, STEP_IDLE);
            default:     w = uw(ACT_NONE, OPA_ONE, OPB_BASE, DEST_PW, 1'b0,
                                COND_ALWAYS, STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/modular_exponentiation_unit.sv =====
// Top level of the modular exponentiation unit: microcoded sequencer and datapath.
// Depends on mexp_pkg and mexp_mulmod.
`default_nettype none

// Computes base ** exponent mod modulus by right-to-left square-and-multiply.
// One beat on the input channel carries a base and an exponent; one beat on the
// output channel carries the result. The modulus register is written through
// i_cfg_we / i_cfg_data; the user must write it only while the unit is idle,
// which the unit itself does not enforce. A written value of zero acts as a
// modulus of one. An exponent of zero yields 1, even with a modulus of one.
// Only the low EXP_BITS bits of the exponent take part. Items are processed one
// at a time; a finished result sits in the output register, so the next beat
// can be taken while it waits. Every modular product goes through a single
// shared radix-2 multiplier that retires one operand bit per cycle; each
// multiply has an issue step and a wait step that holds until it is done.
// The base is first reduced by a multiply by one; then, per exponent bit, a
// set bit multiplies the accumulator by the running power and the power is
// squared. The done and idle steps follow the registered result before the
// next beat can be taken.
module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output      logic             o_in_ready,
    input  wire logic [OPD_W-1:0] i_base,
    input  wire logic [OPD_W-1:0] i_exponent,
    output      logic             o_out_valid,
    input  wire logic             i_out_ready,
    output      logic [MOD_W-1:0] o_power_result,
    input  wire logic             i_cfg_we,
    input  wire logic [MOD_W-1:0] i_cfg_data
);

    // Exponent bits above the port width are always zero, so the register
    // never needs to be wider than the port.
    localparam int EXP_W = (EXP_BITS < OPD_W) ? EXP_BITS : OPD_W;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [MOD_W-1:0]  r_modulus;
    logic [OPD_W-1:0]  r_base;
    logic [EXP_W-1:0]  r_exp;
    logic [MOD_W-1:0]  r_acc;
    logic [MOD_W-1:0]  r_pw;
    t_dest             r_dest;
    logic              r_out_valid;
    logic [MOD_W-1:0]  r_result;

    t_uword            w_uw;
    logic              w_cond;
    logic              w_accept;
    t_mul_req          w_req;
    t_mul_rsp          w_rsp;

    // Fetch the control word of the current step.
    assign w_uw = uprog(r_step);

    assign o_in_ready = (w_uw.act == ACT_ACCEPT);
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        unique case (w_uw.cond)
            COND_NEVER:    w_cond = 1'b0;
            COND_ALWAYS:   w_cond = 1'b1;
            COND_NO_INPUT: w_cond = !i_in_valid;
            COND_MUL_BUSY: w_cond = w_rsp.busy;
            COND_EXP_ZERO: w_cond = (r_exp == '0);
            COND_EXP_EVEN: w_cond = !r_exp[0];
            COND_OUT_FULL: w_cond = r_out_valid;
            default:       w_cond = 1'b1;
        endcase
        n_step = w_cond ? w_uw.target : r_step + STEP_W'(1);
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_req.start = (w_uw.act == ACT_MUL);
        w_req.a     = (w_uw.opa == OPA_PW) ? r_pw : MOD_W'(1);
        case (w_uw.opb)
            OPB_BASE: w_req.b = r_base;
            OPB_ACC:  w_req.b = {1'b0, r_acc};
            OPB_PW:   w_req.b = {1'b0, r_pw};
            default:  w_req.b = r_base;
        endcase
    end

    mexp_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_modulus (r_modulus),
        .o_rsp     (w_rsp)
    );

    // Control state: step counter, modulus register and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_modulus   <= MODULUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (i_cfg_we) begin
                r_modulus <= (i_cfg_data == '0) ? MOD_W'(1) : i_cfg_data;
            end
            if (w_uw.act == ACT_EMIT && !r_out_valid) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base <= i_base;
            r_exp  <= i_exponent[EXP_W-1:0];
            r_acc  <= MOD_W'(1);
        end
        if (w_uw.act == ACT_MUL) begin
            r_dest <= w_uw.dest;
        end
        if (w_uw.shift) begin
            r_exp <= r_exp >> 1;
        end
        if (w_rsp.done) begin
            if (r_dest == DEST_ACC) begin
                r_acc <= w_rsp.result;
            end else begin
                r_pw <= w_rsp.result;
            end
        end
        if (w_uw.act == ACT_EMIT && !r_out_valid) begin
            r_result <= r_acc;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_result;

`ifndef SYNTH
    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("multiply issued while the multiplier is busy");

    a_power_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_TEST) |-> (r_pw < r_modulus))
        else $error("running power not reduced at the exponent test");

    a_acc_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_TEST) |-> ((r_acc < r_modulus) || (r_acc == MOD_W'(1))))
        else $error("accumulator out of range at the exponent test");

    a_ready_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!w_rsp.busy && !w_rsp.done))
        else $error("input taken while a multiply is still in flight");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mexp_mulmod.sv =====
// Radix-2 interleaved modular multiplier: a * b mod m, one bit of b per cycle.
// Depends on mexp_pkg for widths and the request and response structs.
`default_nettype none

module mexp_mulmod
    import mexp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_mul_req         i_req,
    input  wire logic [MOD_W-1:0] i_modulus,
    output t_mul_rsp              o_rsp
);

    localparam int CNT_W = $clog2(OPD_W + 1);
    localparam int SUM_W = MOD_W + 2;

    logic [MOD_W-1:0] r_a;
    logic [OPD_W-1:0] r_b;
    logic [MOD_W-1:0] r_r;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_m1;
    logic [SUM_W-1:0] w_m2;
    logic [MOD_W-1:0] n_r;

    // The operand a never exceeds m and r stays below m, so 2r + a < 3m and
    // one of two parallel subtractions brings it back into range.
    always_comb begin
        w_m1  = {2'b00, i_modulus};
        w_m2  = {1'b0, i_modulus, 1'b0};
        w_sum = {1'b0, r_r, 1'b0} + (r_b[OPD_W-1] ? {2'b00, r_a} : '0);
        if (w_sum >= w_m2) begin
            n_r = MOD_W'(w_sum - w_m2);
        end else if (w_sum >= w_m1) begin
            n_r = MOD_W'(w_sum - w_m1);
        end else begin
            n_r = MOD_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(OPD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            r_r <= '0;
        end else if (r_busy) begin
            r_b <= {r_b[OPD_W-2:0], 1'b0};
            r_r <= n_r;
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_r;

`ifndef SYNTH
    a_done_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_r < i_modulus))
        else $error("multiplier result not reduced below the modulus");

    a_done_pulse : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("multiplier done held for more than one cycle");

    a_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> (r_busy && (r_cnt == CNT_W'(OPD_W))))
        else $error("multiplier did not begin a full pass after start");
`endif

endmodule

`default_nettype wire
